[hdl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define SRFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define SRFC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/srfc_pkg.sv]
package srfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions within the reply frame
  localparam logic [2:0] POS_FIRST   = 3'd0;
  localparam logic [2:0] POS_HUM_HI  = 3'd2;
  localparam logic [2:0] POS_HUM_LO  = 3'd3;
  localparam logic [2:0] POS_TEMP_HI = 3'd4;
  localparam logic [2:0] POS_TEMP_LO = 3'd5;
  localparam logic [2:0] POS_CRC_LO  = 3'd6;
  localparam logic [2:0] POS_CRC_HI  = 3'd7;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       frame_start;
  } srfc_byte_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/srfc_if.sv]
interface srfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface srfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] humidity_tenths;
  logic [15:0] temperature_tenths;
  logic        crc_ok;

  modport source (output valid, output humidity_tenths, output temperature_tenths,
                  output crc_ok, input ready);
  modport sink   (input valid, input humidity_tenths, input temperature_tenths,
                  input crc_ok, output ready);
endinterface

[hdl/srfc_in_stage.sv]
module srfc_in_stage
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  srfc_in_if.sink    in_ch,
  input  logic       advance,
  output srfc_byte_t s1
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       start_r, start_nxt;

  assign in_ch.ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    start_nxt = start_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
      byte_nxt  = in_ch.data_byte;
      start_nxt = in_ch.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r  <= byte_nxt;
    start_r <= start_nxt;
  end

  assign s1 = '{valid: valid_r, data_byte: byte_r, frame_start: start_r};

endmodule

[hdl/srfc_frame_core.sv]
module srfc_frame_core
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  srfc_byte_t s1,
  output logic       advance,
  srfc_out_if.source out_ch
);

  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] hum_r, hum_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_hum_r, out_hum_nxt;
  logic [15:0] out_temp_r, out_temp_nxt;
  logic        out_ok_r, out_ok_nxt;

  logic [2:0]  pos;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic        ok;
  logic        fire;

  assign advance  = !out_valid_r || out_ch.ready;
  assign fire     = advance && s1.valid;
  assign pos      = s1.frame_start ? POS_FIRST : pos_r;
  assign crc_base = (pos == POS_FIRST) ? CRC_INIT : crc_r;
  assign crc_upd  = crc_byte(crc_base, s1.data_byte);
  assign ok       = ({s1.data_byte, crc_lo_r} == crc_r);

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    hum_nxt       = hum_r;
    temp_nxt      = temp_r;
    crc_lo_nxt    = crc_lo_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hum_nxt   = out_hum_r;
    out_temp_nxt  = out_temp_r;
    out_ok_nxt    = out_ok_r;
    if (fire) begin
      pos_nxt = pos + 3'd1;
      if (pos <= POS_TEMP_LO) begin
        crc_nxt = crc_upd;
      end
      unique case (pos)
        POS_HUM_HI:  hum_nxt    = {s1.data_byte, hum_r[7:0]};
        POS_HUM_LO:  hum_nxt    = {hum_r[15:8], s1.data_byte};
        POS_TEMP_HI: temp_nxt   = {s1.data_byte, temp_r[7:0]};
        POS_TEMP_LO: temp_nxt   = {temp_r[15:8], s1.data_byte};
        POS_CRC_LO:  crc_lo_nxt = s1.data_byte;
        POS_CRC_HI: begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok;
          out_hum_nxt   = ok ? hum_r : 16'h0000;
          out_temp_nxt  = ok ? temp_r : 16'h0000;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_FIRST;
      crc_r       <= CRC_INIT;
      hum_r       <= 16'h0000;
      temp_r      <= 16'h0000;
      crc_lo_r    <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      hum_r       <= hum_nxt;
      temp_r      <= temp_nxt;
      crc_lo_r    <= crc_lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_hum_r  <= out_hum_nxt;
    out_temp_r <= out_temp_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.humidity_tenths    = out_hum_r;
  assign out_ch.temperature_tenths = out_temp_r;
  assign out_ch.crc_ok             = out_ok_r;

endmodule

[hdl/sensor_reply_frame_checker.sv]
// Checks the 8-byte reply frame of a humidity and temperature sensor, one byte per transfer.
// A CRC-16/MODBUS (reflected, polynomial 0xA001, start 0xFFFF) runs over bytes 0 to 5 and is
// compared with the little-endian CRC in bytes 6 and 7. Byte 7 yields one result: humidity and
// temperature as raw big-endian counts in tenths (both zero on a mismatch) and crc_ok. A set
// frame_start restarts the frame and drops any partial one; after byte 7 the next byte is byte 0.
// The block takes one byte every cycle: an input register feeds a byte-wide CRC update, and
// a result register drives the output, so byte 7 passes the input register, then the result
// register. Backpressure on the output stalls the input only once both registers hold.
module sensor_reply_frame_checker
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  srfc_in_if.sink    in_ch,
  srfc_out_if.source out_ch
);

  srfc_byte_t s1;
  logic       advance;

  srfc_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .s1      (s1)
  );

  srfc_frame_core u_frame_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1      (s1),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

[hdl/srfc_checker.sv]
`include "assert_macros.svh"

module srfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_hum,
  input logic [15:0] out_temp,
  input logic        out_ok
);

  logic in_xfer;
  logic vals_zero;

  assign in_xfer   = in_valid && in_ready;
  assign vals_zero = (out_hum == 16'h0000) && (out_temp == 16'h0000);

  `SRFC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `SRFC_ASSERT(a_zero_on_err, out_valid && !out_ok |-> vals_zero, "values not zero on CRC error")
  `SRFC_ASSERT(a_rise_after_xfer, $rose(out_valid) |-> $past(in_xfer, 2), "result without transfer")
  `SRFC_ASSERT_RST(a_reset_idle, $past(!rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind sensor_reply_frame_checker srfc_checker u_srfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hum   (out_ch.humidity_tenths),
  .out_temp  (out_ch.temperature_tenths),
  .out_ok    (out_ch.crc_ok)
);
